// ----- rtl/core/vtp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vtp_pkg;

   localparam int MAX_SEGMENTS_DEF  = 256;
   localparam int DURATION_BITS_DEF = 16;

   localparam int TOTAL_W  = 24;
   localparam int SUM_W    = TOTAL_W + 1;
   localparam int DUR_IN_W = 16;
   localparam int LETTER_W = 8;
   localparam int DIM_W    = 8;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
   localparam logic [DIM_W-1:0]   DEFAULT_DIM = 8'd100;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_START  = 2'd2,
      KIND_TICK   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [DUR_IN_W-1:0]   duration_frames;
      logic [LETTER_W-1:0]   phoneme;
      logic                  sound_playing;
   } req_type;

   typedef struct packed {
      logic [DIM_W-1:0] mouth_width;
      logic [DIM_W-1:0] mouth_height;
      logic             segment_found;
   } rsp_type;

   // Status of the timeline walk, from the walker to the top level.
   typedef struct packed {
      logic                busy;
      logic                done;
      logic                found;
      logic [LETTER_W-1:0] letter;
   } walk_stat_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } shape_type;

   // Mouth shape for a phoneme letter; unknown letters give the neutral shape.
   function automatic shape_type shape_of(input logic [LETTER_W-1:0] letter);
      shape_type s;
      s.width  = DEFAULT_DIM;
      s.height = DEFAULT_DIM;
      case (letter)
         "a": begin s.width = 8'd150; s.height = 8'd100; end
         "i": begin s.width = 8'd120; s.height = 8'd50;  end
         "u": begin s.width = 8'd80;  s.height = 8'd100; end
         "e": begin s.width = 8'd155; s.height = 8'd85;  end
         "o": begin s.width = 8'd130; s.height = 8'd130; end
         "k": begin s.width = 8'd110; s.height = 8'd70;  end
         "s": begin s.width = 8'd140; s.height = 8'd55;  end
         "t": begin s.width = 8'd120; s.height = 8'd30;  end
         "n": begin s.width = 8'd110; s.height = 8'd20;  end
         "h": begin s.width = 8'd140; s.height = 8'd60;  end
         "m": begin s.width = 8'd80;  s.height = 8'd20;  end
         "y": begin s.width = 8'd115; s.height = 8'd35;  end
         "w": begin s.width = 8'd110; s.height = 8'd45;  end
         "g": begin s.width = 8'd90;  s.height = 8'd55;  end
         "z": begin s.width = 8'd115; s.height = 8'd55;  end
         "d": begin s.width = 8'd120; s.height = 8'd20;  end
         "p": begin s.width = 8'd75;  s.height = 8'd30;  end
         default: begin s.width = DEFAULT_DIM; s.height = DEFAULT_DIM; end
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vtp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface vtp_req_if;
   import vtp_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface vtp_rsp_if;
   import vtp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/vtp_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One segment slot of the ring; takes its neighbor's segment on each shift.
module vtp_cell #(
   parameter int DURATION_BITS = vtp_pkg::DURATION_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         shift,
   input  wire logic [DURATION_BITS-1:0]     dur_in,
   input  wire logic [vtp_pkg::LETTER_W-1:0] letter_in,
   output logic      [DURATION_BITS-1:0]     dur_out,
   output logic      [vtp_pkg::LETTER_W-1:0] letter_out
);
   import vtp_pkg::*;

   logic [DURATION_BITS-1:0] dur_ff;
   logic [LETTER_W-1:0]      letter_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         dur_ff    <= dur_in;
         letter_ff <= letter_in;
      end
   end

   assign dur_out    = dur_ff;
   assign letter_out = letter_ff;

endmodule

`default_nettype wire

// ----- rtl/core/vtp_walker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Walks one full turn of the ring, summing the durations of the live
// entries as they pass the head cell and latching the first letter whose
// running sum reaches the frame tick.
module vtp_walker #(
   parameter int MAX_SEGMENTS  = vtp_pkg::MAX_SEGMENTS_DEF,
   parameter int DURATION_BITS = vtp_pkg::DURATION_BITS_DEF,
   localparam int IDX_W = $clog2(MAX_SEGMENTS),
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [vtp_pkg::TOTAL_W-1:0]  frame_tick,
   input  wire logic [CNT_W-1:0]             first_pos,
   input  wire logic [DURATION_BITS-1:0]     head_dur,
   input  wire logic [vtp_pkg::LETTER_W-1:0] head_letter,
   output vtp_pkg::walk_stat_type            stat
);
   import vtp_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SEGMENTS - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [LETTER_W-1:0] letter_ff, letter_in;

   logic [SUM_W-1:0]    sum_add;
   logic [SUM_W-1:0]    sum_sat;
   logic                live;

   always_comb begin
      sum_add = sum_ff + SUM_W'(head_dur);
      // Saturate at 2^24: every frame tick lies below, so compares still hold.
      sum_sat = sum_add[TOTAL_W] ? (SUM_W'(1) << TOTAL_W) : sum_add;
      live    = CNT_W'(idx_ff) >= first_pos;

      busy_in   = busy_ff;
      done_in   = 1'b0;
      found_in  = found_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      letter_in = letter_ff;

      if (start) begin
         busy_in  = 1'b1;
         found_in = 1'b0;
         idx_in   = '0;
         sum_in   = '0;
      end else if (busy_ff) begin
         idx_in = idx_ff + IDX_W'(1);
         if (live && !found_ff) begin
            sum_in = sum_sat;
            if (sum_sat >= SUM_W'(frame_tick)) begin
               found_in  = 1'b1;
               letter_in = head_letter;
            end
         end
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         found_ff <= found_in;
         idx_ff   <= idx_in;
      end
      sum_ff    <= sum_in;
      letter_ff <= letter_in;
   end

   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;
   assign stat.found  = found_ff;
   assign stat.letter = letter_ff;

endmodule

`default_nettype wire

// ----- rtl/core/viseme_timeline_player_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Viseme timeline player. Segments (a duration in frames and a phoneme
// letter) are kept in a ring of MAX_SEGMENTS cells; the live entries sit at
// the tail end of the ring, oldest first. Clear, append and start beats give
// no result. A frame tick beat gives one result beat with the mouth width and
// height in hundredths (100,100 is the neutral shape). When playback is
// stopped, the sound has ended, or the tick has reached the total, the
// result is registered and ready in the cycle after the beat. For a tick
// inside the timeline the ring turns once, one cell per clock, so the head
// cell sees every entry in order while a running sum finds the matching
// segment; after that turn the ring is back in its original order. The block
// works on one beat at a time. A finished result waits in the output register
// and the next beat is still accepted as long as that register is free or
// being emptied in the same cycle. The total saturates at 2^24 - 1 frames,
// and an append to a full table is dropped.
module viseme_timeline_player_unit #(
   parameter int MAX_SEGMENTS  = vtp_pkg::MAX_SEGMENTS_DEF,
   parameter int DURATION_BITS = vtp_pkg::DURATION_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   vtp_req_if.sink   req_port,
   vtp_rsp_if.source rsp_port
);
   import vtp_pkg::*;

   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   // Ring of segment cells. Cell 0 is the head; a shift moves every cell's
   // segment one place toward the head and feeds the tail cell.
   logic [DURATION_BITS-1:0] cell_dur    [MAX_SEGMENTS];
   logic [LETTER_W-1:0]      cell_letter [MAX_SEGMENTS];
   logic [DURATION_BITS-1:0] tail_dur;
   logic [LETTER_W-1:0]      tail_letter;
   logic                     ring_shift;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] tick_ff, tick_in;
   logic               playing_ff, playing_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   walk_stat_type            walk_stat;
   logic                     walk_start;
   logic                     req_fire;
   logic                     slot_free;
   logic                     do_append;
   logic [DURATION_BITS-1:0] new_dur;
   logic [TOTAL_W:0]         total_add;
   shape_type                shape;

   assign slot_free = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire = req_port.valid && req_port.ready;

   assign new_dur   = DURATION_BITS'(req_port.data.duration_frames);
   assign do_append = req_fire && (req_port.data.kind == KIND_APPEND)
                      && (count_ff < MAX_CNT);

   // Appends take the new segment into the tail; a walk wraps the head around.
   assign ring_shift  = do_append || walk_stat.busy;
   assign tail_dur    = do_append ? new_dur : cell_dur[0];
   assign tail_letter = do_append ? req_port.data.phoneme : cell_letter[0];

   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_ring
      if (i == MAX_SEGMENTS - 1) begin : g_tail
         vtp_cell #(.DURATION_BITS(DURATION_BITS)) u_cell (
            .clock      (clock),
            .shift      (ring_shift),
            .dur_in     (tail_dur),
            .letter_in  (tail_letter),
            .dur_out    (cell_dur[i]),
            .letter_out (cell_letter[i])
         );
      end else begin : g_mid
         vtp_cell #(.DURATION_BITS(DURATION_BITS)) u_cell (
            .clock      (clock),
            .shift      (ring_shift),
            .dur_in     (cell_dur[i+1]),
            .letter_in  (cell_letter[i+1]),
            .dur_out    (cell_dur[i]),
            .letter_out (cell_letter[i])
         );
      end
   end

   vtp_walker #(
      .MAX_SEGMENTS  (MAX_SEGMENTS),
      .DURATION_BITS (DURATION_BITS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (walk_start),
      .frame_tick  (tick_ff),
      .first_pos   (MAX_CNT - count_ff),
      .head_dur    (cell_dur[0]),
      .head_letter (cell_letter[0]),
      .stat        (walk_stat)
   );

   assign total_add = {1'b0, total_ff} + (TOTAL_W + 1)'(new_dur);
   assign shape     = shape_of(walk_stat.letter);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      tick_in      = tick_ff;
      playing_in   = playing_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_data_in  = rsp_data_ff;
      walk_start   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_port.data.kind)
                  KIND_CLEAR: begin
                     count_in   = '0;
                     total_in   = '0;
                     tick_in    = '0;
                     playing_in = 1'b0;
                  end
                  KIND_APPEND: begin
                     if (do_append) begin
                        count_in = count_ff + CNT_W'(1);
                        total_in = total_add[TOTAL_W] ? TOTAL_MAX
                                                      : total_add[TOTAL_W-1:0];
                     end
                  end
                  KIND_START: begin
                     playing_in = 1'b1;
                  end
                  KIND_TICK: begin
                     rsp_data_in.mouth_width   = DEFAULT_DIM;
                     rsp_data_in.mouth_height  = DEFAULT_DIM;
                     rsp_data_in.segment_found = 1'b0;
                     if (!playing_ff) begin
                        tick_in      = '0;
                        rsp_valid_in = 1'b1;
                     end else if (!req_port.data.sound_playing) begin
                        playing_in   = 1'b0;
                        rsp_valid_in = 1'b1;
                     end else if (total_ff <= tick_ff) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        walk_start = 1'b1;
                        state_in   = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (walk_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (walk_stat.found) begin
                  rsp_data_in.mouth_width   = shape.width;
                  rsp_data_in.mouth_height  = shape.height;
                  rsp_data_in.segment_found = 1'b1;
                  tick_in = tick_ff + TOTAL_W'(1);
               end else begin
                  rsp_data_in.mouth_width   = DEFAULT_DIM;
                  rsp_data_in.mouth_height  = DEFAULT_DIM;
                  rsp_data_in.segment_found = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         tick_ff      <= '0;
         playing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         tick_ff      <= tick_in;
         playing_ff   <= playing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// Tracks the player state beat by beat and holds the mouth shapes that the
// frame ticks should produce, oldest first.
class mouth_shape_tracker;
   bit [15:0] seg_frames [vtp_pkg::MAX_SEGMENTS_DEF];
   bit [7:0]  seg_letter [vtp_pkg::MAX_SEGMENTS_DEF];
   int unsigned seg_count;
   bit [23:0] total_frames;
   bit [23:0] tick_pos;
   bit        playing;

   vtp_pkg::rsp_type pending_shapes[$];

   int unsigned faults;
   int unsigned shapes_checked;
   int unsigned segments_matched;
   int unsigned appends_dropped;
   int unsigned sound_stops;

   function new();
      seg_count    = 0;
      total_frames = '0;
      tick_pos     = '0;
      playing      = 1'b0;
      faults = 0;
      shapes_checked = 0;
      segments_matched = 0;
      appends_dropped = 0;
      sound_stops = 0;
   endfunction

   // Phoneme letter to mouth width and height; any other letter is neutral.
   function void shape_for(input bit [7:0] letter, output bit [7:0] w,
                           output bit [7:0] h);
      bit [7:0] keys [17]  = '{"a", "i", "u", "e", "o", "k", "s", "t", "n",
                               "h", "m", "y", "w", "g", "z", "d", "p"};
      bit [7:0] wides [17] = '{150, 120, 80, 155, 130, 110, 140, 120, 110,
                               140, 80, 115, 110, 90, 115, 120, 75};
      bit [7:0] highs [17] = '{100, 50, 100, 85, 130, 70, 55, 30, 20,
                               60, 20, 35, 45, 55, 55, 20, 30};
      w = vtp_pkg::DEFAULT_DIM;
      h = vtp_pkg::DEFAULT_DIM;
      for (int k = 0; k < 17; k++) begin
         if (keys[k] == letter) begin
            w = wides[k];
            h = highs[k];
         end
      end
   endfunction

   function void note_request(vtp_pkg::req_type beat);
      vtp_pkg::rsp_type shape;
      int unsigned sum;
      bit hit;
      case (beat.kind)
         vtp_pkg::KIND_CLEAR: begin
            seg_count    = 0;
            total_frames = '0;
            tick_pos     = '0;
            playing      = 1'b0;
         end
         vtp_pkg::KIND_APPEND: begin
            if (seg_count < vtp_pkg::MAX_SEGMENTS_DEF) begin
               seg_frames[seg_count] = beat.duration_frames;
               seg_letter[seg_count] = beat.phoneme;
               seg_count++;
               sum = total_frames + beat.duration_frames;
               total_frames = (sum > vtp_pkg::TOTAL_MAX) ? vtp_pkg::TOTAL_MAX : sum[23:0];
            end else begin
               appends_dropped++;
            end
         end
         vtp_pkg::KIND_START: begin
            playing = 1'b1;
         end
         default: begin
            shape.mouth_width   = vtp_pkg::DEFAULT_DIM;
            shape.mouth_height  = vtp_pkg::DEFAULT_DIM;
            shape.segment_found = 1'b0;
            if (!playing) begin
               tick_pos = '0;
            end else if (!beat.sound_playing) begin
               playing = 1'b0;
               sound_stops++;
            end else if (total_frames > tick_pos) begin
               sum = 0;
               hit = 1'b0;
               for (int unsigned i = 0; i < seg_count && !hit; i++) begin
                  sum += seg_frames[i];
                  if (sum >= tick_pos) begin
                     hit = 1'b1;
                     shape_for(seg_letter[i], shape.mouth_width, shape.mouth_height);
                     shape.segment_found = 1'b1;
                     tick_pos = tick_pos + 24'd1;
                     segments_matched++;
                  end
               end
            end
            pending_shapes = {pending_shapes, shape};
         end
      endcase
   endfunction

   function void note_fault(string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
   endfunction

   function void check_shape(vtp_pkg::rsp_type got);
      vtp_pkg::rsp_type want;
      if (pending_shapes.size() == 0) begin
         note_fault($sformatf("[%0t] shape beat with nothing expected: w=%0d h=%0d found=%0b",
                              $time, got.mouth_width, got.mouth_height, got.segment_found));
         return;
      end
      want = pending_shapes.pop_front();
      shapes_checked++;
      if (got.mouth_width !== want.mouth_width || got.mouth_height !== want.mouth_height ||
          got.segment_found !== want.segment_found) begin
         note_fault($sformatf({"[%0t] shape mismatch: w exp %0d got %0d, ",
                               "h exp %0d got %0d, found exp %0b got %0b"},
                              $time, want.mouth_width, got.mouth_width, want.mouth_height,
                              got.mouth_height, want.segment_found, got.segment_found));
      end
   endfunction
endclass

module tb_top;
   import vtp_pkg::*;

   // Cycles with no beat on either side before the run is declared hung.
   // A tick inside the timeline costs one full turn of the segment ring,
   // plus the random stalls on each side, so this leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 2000;
   // Drain time after the last expected shape, covering one ring turn.
   localparam int DRAIN_CYCLES   = 300;
   localparam int ITEM_TARGET    = 1400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vtp_req_if req_bus ();
   vtp_rsp_if rsp_bus ();

   viseme_timeline_player_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   mouth_shape_tracker tracker = new();

   // Every letter that has a shape of its own; stimulus draws mostly from here.
   string phonemes = "aiueoksthnmywgzdp";

   int  beats_sent  = 0;
   int  idle_cycles = 0;
   // Set near the end of the run: from then on neither side idles.
   bit  calm_tail   = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Monitor both channels at the rising edge. Values read here are the ones
   // the block saw at this edge, since all drivers use nonblocking updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) tracker.note_request(req_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) tracker.check_shape(rsp_bus.data);
      end
   end

   // Hang detection: count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d shapes still expected",
                     idle_cycles, tracker.pending_shapes.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Result side: ready drops in random bursts.
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm_tail && hold == 0 && $urandom_range(0, 5) == 0)
            hold = $urandom_range(1, 8);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Drives one request beat and returns at the edge where it is taken.
   // Before the beat the sender may go quiet for a random burst.
   task automatic send_req(input kind_type kind, input logic [15:0] frames,
                           input logic [7:0] letter, input logic sound);
      req_type beat;
      beat.kind            = kind;
      beat.duration_frames = frames;
      beat.phoneme         = letter;
      beat.sound_playing   = sound;
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= beat;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
      if (beats_sent >= ITEM_TARGET * 85 / 100) calm_tail = 1'b1;
   endtask

   initial begin
      int n;
      int ticks;
      int span;
      int fills;
      int pick;
      logic [15:0] frames;
      logic [7:0]  letter;
      logic        sound;

      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening. A tick before any start must report neutral and
      // zero the tick; a start on an empty table leaves every tick at the end.
      send_req(KIND_TICK,   16'h0000, 8'h00, 1'b1);
      send_req(KIND_START,  16'hFFFF, 8'hFF, 1'b0);
      send_req(KIND_TICK,   16'h0000, 8'h00, 1'b1);
      // A zero-length first segment still matches tick zero, then a letter
      // outside the shape table gives neutral with the found flag set.
      send_req(KIND_APPEND, 16'h0000, "a",   1'b0);
      send_req(KIND_APPEND, 16'h0001, 8'hFF, 1'b1);
      send_req(KIND_APPEND, 16'hFFFF, "e",   1'b0);
      send_req(KIND_APPEND, 16'h0002, 8'h00, 1'b0);
      send_req(KIND_TICK,   16'hFFFF, 8'hFF, 1'b1);
      send_req(KIND_TICK,   16'h0000, 8'h00, 1'b1);
      send_req(KIND_TICK,   16'h0000, 8'h00, 1'b1);
      // Sound ends: playback stops with the tick held, and the next tick
      // while stopped brings it back to zero.
      send_req(KIND_TICK,   16'h0000, 8'h00, 1'b0);
      send_req(KIND_TICK,   16'h0000, 8'h00, 1'b1);
      send_req(KIND_START,  16'h0000, 8'h00, 1'b1);
      send_req(KIND_TICK,   16'h0000, 8'h00, 1'b1);
      // Clear, then a short timeline played past its end, where the tick holds.
      send_req(KIND_CLEAR,  16'hFFFF, 8'hFF, 1'b1);
      send_req(KIND_APPEND, 16'h0003, "o",   1'b1);
      send_req(KIND_APPEND, 16'h0001, "p",   1'b0);
      send_req(KIND_START,  16'h0000, 8'h00, 1'b0);
      repeat (7) send_req(KIND_TICK, 16'h0000, 8'h00, 1'b1);

      // Random part, made mostly of well-formed timelines: clear, a few
      // appends, start, then a run of ticks that walks through the segments
      // and usually past the end. Some runs fill the table to overflow and
      // some are bursts of fully random beats.
      fills = 0;
      while (beats_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (fills == 0 || (pick < 3 && fills < 3 &&
                            beats_sent + MAX_SEGMENTS_DEF + 10 < ITEM_TARGET)) begin
            // Fill the table with long segments; the last appends are dropped.
            fills++;
            send_req(KIND_CLEAR, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
            for (int i = 0; i < MAX_SEGMENTS_DEF + 3; i++) begin
               frames = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
               send_req(KIND_APPEND, frames, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
            end
            send_req(KIND_START, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
            repeat (4) send_req(KIND_TICK, 16'($urandom), 8'($urandom), 1'b1);
         end else if (pick < 14) begin
            repeat ($urandom_range(1, 6))
               send_req(kind_type'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                        1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 4) != 0)
               send_req(KIND_CLEAR, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
            n = $urandom_range(1, 8);
            span = 0;
            for (int i = 0; i < n; i++) begin
               frames = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
               letter = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                        phonemes[$urandom_range(0, 16)];
               send_req(KIND_APPEND, frames, letter, 1'($urandom_range(0, 1)));
               span += frames;
            end
            send_req(KIND_START, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
            ticks = $urandom_range(1, ((span > 30) ? 30 : span) + 3);
            for (int i = 0; i < ticks; i++) begin
               sound = ($urandom_range(0, 19) != 0);
               send_req(KIND_TICK, 16'($urandom), 8'($urandom), sound);
               if (!sound && $urandom_range(0, 1))
                  send_req(KIND_START, 16'($urandom), 8'($urandom),
                           1'($urandom_range(0, 1)));
            end
         end
      end
      req_bus.valid <= 1'b0;

      // Wait for every expected shape, then let a full ring turn pass so that
      // a stray extra result would still be caught. The watchdog bounds this.
      while (tracker.pending_shapes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.pending_shapes.size() != 0)
         tracker.note_fault($sformatf("%0d shapes never arrived",
                                      tracker.pending_shapes.size()));

      $display("Sent %0d request beats including %0d table fills; checked %0d shape beats.",
               beats_sent, fills, tracker.shapes_checked);
      $display("%0d ticks matched a segment, %0d stopped on silence, %0d appends dropped.",
               tracker.segments_matched, tracker.sound_stops, tracker.appends_dropped);
      if (tracker.faults == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d failures", tracker.faults);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
